### design/apr_pkg.sv
// shared types and constants for the aging page replacement block
`default_nettype none
package apr_pkg;

  // table geometry
  localparam int FRAMES    = 128;
  localparam int AGE_BITS  = 32;
  localparam int PAGE_BITS = 16;
  localparam int IDX_W     = $clog2(FRAMES);
  localparam int FILL_W    = $clog2(FRAMES + 1);

  // stream field widths
  localparam int PAGE_NUM_W = 16;
  localparam int FRAME_W    = 7;
  localparam int EVP_W      = 16;
  localparam int TOTAL_W    = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;

  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS - 1){1'b0}}};
  localparam logic [TOTAL_W-1:0]  COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/apr_ctrl.sv
// sequencer for one reference: accept, scan all frames, flush the read pipeline, commit result
`default_nettype none
module apr_ctrl import apr_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.rd_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_FLUSH: begin
      end
      ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### design/apr_dp.sv
// frame table memories, scan evaluation, hit counter and output register
`default_nettype none
module apr_dp import apr_pkg::*; (
  input  wire                   clk,
  input  wire                   rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  wire  [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // frame table storage
  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [AGE_BITS-1:0]  age_mem  [FRAMES];

  logic [PAGE_BITS-1:0] page;
  logic [IDX_W-1:0]     rd_addr;
  logic                 ev_vld;
  logic [IDX_W-1:0]     ev_addr;
  logic [PAGE_BITS-1:0] pg_q;
  logic [AGE_BITS-1:0]  age_q;
  logic                 found;
  logic [IDX_W-1:0]     slot;
  logic [AGE_BITS-1:0]  hit_age;
  logic [AGE_BITS-1:0]  best_age;
  logic [IDX_W-1:0]     best_idx;
  logic [PAGE_BITS-1:0] best_page;
  logic [FILL_W-1:0]    fill;
  logic [TOTAL_W-1:0]   hit_counter;

  logic                 o_hit;
  logic [FRAME_W-1:0]   o_frame;
  logic                 o_ev_valid;
  logic [EVP_W-1:0]     o_ev_page;
  logic [TOTAL_W-1:0]   o_total;

  logic                 eval_valid;
  logic                 eval_match;
  logic                 eval_better;
  logic                 full;
  logic [IDX_W-1:0]     vslot;
  logic [TOTAL_W-1:0]   hit_counter_next;
  logic                 pg_we;
  logic [IDX_W-1:0]     pg_wa;
  logic                 age_we;
  logic [IDX_W-1:0]     age_wa;
  logic [AGE_BITS-1:0]  age_wd;

  // status back to the controller
  assign sts.rd_last  = (rd_addr == IDX_W'(FRAMES - 1));
  assign sts.out_free = !m_tvalid || m_tready;

  // per-frame evaluation of the registered read data
  assign eval_valid  = ({1'b0, ev_addr} < fill);
  assign eval_match  = ev_vld && eval_valid && (pg_q == page) && !found;
  assign eval_better = (ev_addr == '0) || (age_q < best_age);

  // commit decisions
  assign full  = (fill == FILL_W'(FRAMES));
  assign vslot = found ? slot : (full ? best_idx : fill[IDX_W-1:0]);
  assign hit_counter_next = (found && hit_counter != COUNT_MAX) ?
                            hit_counter + 1'b1 : hit_counter;

  // memory write ports: scan write-back or final update
  always_comb begin
    pg_we  = cmd.commit && !found;
    pg_wa  = vslot;
    age_we = 1'b0;
    age_wa = ev_addr;
    age_wd = age_q >> 1;
    if (cmd.commit) begin
      age_we = 1'b1;
      age_wa = vslot;
      age_wd = found ? hit_age : AGE_TOP;
    end else if (ev_vld && eval_valid) begin
      age_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pg_we) page_mem[pg_wa] <= page;
  end

  always_ff @(posedge clk) begin
    if (age_we) age_mem[age_wa] <= age_wd;
  end

  // registered reads during the scan
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      pg_q  <= page_mem[rd_addr];
      age_q <= age_mem[rd_addr];
    end
  end

  // scan address and read pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      ev_vld  <= 1'b0;
    end else begin
      ev_vld <= cmd.scan_rd;
      if (cmd.load) begin
        rd_addr <= '0;
      end else if (cmd.scan_rd) begin
        rd_addr <= rd_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_addr <= rd_addr;
  end

  // tag match and minimum-age tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
    end else if (eval_match) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) page <= PAGE_BITS'(s_tdata[PAGE_NUM_W-1:0]);
    if (eval_match) begin
      slot    <= ev_addr;
      hit_age <= (age_q >> 1) | AGE_TOP;
    end
    if (ev_vld && eval_better) begin
      best_age  <= age_q;
      best_idx  <= ev_addr;
      best_page <= pg_q;
    end
  end

  // fill count and hit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      hit_counter <= '0;
    end else if (cmd.commit) begin
      hit_counter <= hit_counter_next;
      if (!found && !full) fill <= fill + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_hit      <= found;
      o_frame    <= FRAME_W'(vslot);
      o_ev_valid <= !found && full;
      o_ev_page  <= (!found && full) ? EVP_W'(best_page) : '0;
      o_total    <= hit_counter_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - TOTAL_W - EVP_W - FRAME_W - 2){1'b0}},
                    o_total, o_ev_page, o_ev_valid, o_frame, o_hit};

endmodule
`default_nettype wire

### design/aging_page_replacement.sv
// top level of the aging page replacement block
//
// One page reference enters on the s_ channel per beat; s_tdata[15:0] is the
// page number. Each reference yields exactly one result beat on the m_ channel.
// The block takes one reference at a time: after acceptance it reads every
// frame of the table once through the single read port of the page and age
// memories (one frame per cycle), then drains the read pipeline in its flush
// step and writes back the chosen frame in its commit step. s_tready is high
// again in the cycle the result becomes valid, so a new reference is taken
// only once the last one is through.
// The result sits in an output register until taken; if the receiver stalls,
// the block still accepts and scans the next reference and holds in its
// commit step until the output register is free.
// Reset clears the fill count (all frames empty), the hit counter and the
// output valid; the memories need no clearing pass since frames fill in
// index order and only filled frames are evaluated.
`default_nettype none
module aging_page_replacement import apr_pkg::*; (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  // [15:0] page_number
  input  wire  [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  // [0] hit, [7:1] frame, [8] evicted_valid, [24:9] evicted_page,
  // [56:25] hit_total, [63:57] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  apr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // frame table and result datapath
  apr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

### design/apr_checker.sv
// port-level checks for the aging page replacement block
`default_nettype none
module apr_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [63:0] m_tdata
);

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one reference at a time: busy after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  // a hit never reports an eviction
  a_hit_ev: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[8]))
    else $error("hit with eviction");

endmodule

bind aging_page_replacement apr_checker u_apr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

### verif/aging_page_replacement_tb.sv
// self-checking testbench for the aging page replacement block
`default_nettype none
module aging_page_replacement_tb import apr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1430;
  localparam int POOL_N       = 192;
  localparam int HOT_N        = 24;
  localparam int SETTLE_CYCLES = 2 * (FRAMES + 3) + 20;

  // one result beat, laid out as on m_tdata (hit in bit 0)
  typedef struct packed {
    logic [OUT_DATA_W-TOTAL_W-EVP_W-FRAME_W-3:0] pad;
    logic [TOTAL_W-1:0]   hit_total;
    logic [EVP_W-1:0]     evicted_page;
    logic                 evicted_valid;
    logic [FRAME_W-1:0]   frame;
    logic                 hit;
  } lookup_t;

  typedef struct {
    logic [PAGE_NUM_W-1:0] page;
    bit                    typed;
    lookup_t               want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] m_tdata;

  aging_page_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // shadow of the frame table
  logic [PAGE_BITS-1:0] shadow_page  [FRAMES];
  bit                   shadow_valid [FRAMES];
  logic [AGE_BITS-1:0]  shadow_age   [FRAMES];
  logic [TOTAL_W-1:0]   shadow_hits;

  lookup_t   lookups_due [$];
  stim_row_t directed_rows [$];
  logic [PAGE_NUM_W-1:0] page_pool [POOL_N];
  int  mismatch_count = 0;
  bit  drain_all = 1'b0;
  int  rx_run = 0;
  int  rx_kind;

  // every valid frame gets one shift right per reference
  function automatic void shift_ages();
    int i;
    for (i = 0; i < FRAMES; i++) begin
      if (shadow_valid[i]) begin
        shadow_age[i] = shadow_age[i] >> 1;
      end
    end
  endfunction

  // apply one reference to the shadow table and return the beat it yields
  function automatic lookup_t lookup_page(input logic [PAGE_NUM_W-1:0] raw);
    lookup_t             r;
    logic [PAGE_BITS-1:0] pg;
    logic [AGE_BITS-1:0]  best;
    int  slot;
    int  i;
    bit  found;
    bit  empty;
    r = '0;
    pg = raw[PAGE_BITS-1:0];
    slot = 0;
    found = 1'b0;
    empty = 1'b0;
    for (i = 0; i < FRAMES; i++) begin
      if (!found && shadow_valid[i] && shadow_page[i] == pg) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (shadow_hits != COUNT_MAX) begin
        shadow_hits = shadow_hits + 1;
      end
      shift_ages();
      shadow_age[slot] = shadow_age[slot] | AGE_TOP;
    end else begin
      for (i = 0; i < FRAMES; i++) begin
        if (!empty && !shadow_valid[i]) begin
          slot = i;
          empty = 1'b1;
        end
      end
      // table full: oldest frame goes, lowest index wins a tie
      if (!empty) begin
        best = shadow_age[0];
        slot = 0;
        for (i = 1; i < FRAMES; i++) begin
          if (shadow_age[i] < best) begin
            best = shadow_age[i];
            slot = i;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page = EVP_W'(shadow_page[slot]);
      end
      shift_ages();
      shadow_page[slot] = pg;
      shadow_valid[slot] = 1'b1;
      shadow_age[slot] = AGE_TOP;
    end
    r.hit = found;
    r.frame = FRAME_W'(slot);
    r.hit_total = shadow_hits;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input logic [PAGE_NUM_W-1:0] pg, input bit typed,
                         input logic hit, input int frame, input int total);
    stim_row_t row;
    row.page = pg;
    row.typed = typed;
    row.want = '0;
    row.want.hit = hit;
    row.want.frame = FRAME_W'(frame);
    row.want.hit_total = TOTAL_W'(total);
    directed_rows.push_back(row);
  endtask

  // hold valid low for a while, then offer one page until it is taken
  task automatic offer_page(input logic [PAGE_NUM_W-1:0] pg, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pg;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // mostly short gaps in bursts, now and then a long one; none for items 900 to 1099
  function automatic int pick_gap(input int n, inout int burst_left);
    int k;
    if (n >= 900 && n < 1100) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 12);
    k = $urandom_range(0, 9);
    if (k < 5) return 0;
    if (k < 9) return $urandom_range(1, 20);
    return $urandom_range(40, 250);
  endfunction

  // result side: check each beat, stall on a pattern of its own
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_run <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (lookups_due.size() == 0) begin
          flag_mismatch("unexpected beat", m_tdata[31:0], '0);
        end else begin
          lookup_t got;
          lookup_t want;
          got = lookup_t'(m_tdata);
          want = lookups_due.pop_front();
          if (got.hit !== want.hit)
            flag_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.frame !== want.frame)
            flag_mismatch("frame", 32'(got.frame), 32'(want.frame));
          if (got.evicted_valid !== want.evicted_valid)
            flag_mismatch("evicted_valid", 32'(got.evicted_valid),
                          32'(want.evicted_valid));
          if (got.evicted_page !== want.evicted_page)
            flag_mismatch("evicted_page", 32'(got.evicted_page),
                          32'(want.evicted_page));
          if (got.hit_total !== want.hit_total)
            flag_mismatch("hit_total", got.hit_total, want.hit_total);
          if (got.pad !== want.pad)
            flag_mismatch("pad", 32'(got.pad), 32'(want.pad));
        end
      end
      if (drain_all) begin
        m_tready <= 1'b1;
      end else if (rx_run == 0) begin
        rx_kind = $urandom_range(0, 9);
        if (rx_kind < 4) begin
          m_tready <= 1'b1;
          rx_run <= $urandom_range(1, 400);
        end else if (rx_kind < 8) begin
          m_tready <= 1'b0;
          rx_run <= $urandom_range(1, 8);
        end else if (rx_kind == 8) begin
          m_tready <= 1'b0;
          rx_run <= $urandom_range(100, 300);
        end else begin
          m_tready <= 1'($urandom_range(0, 1));
          rx_run <= 0;
        end
      end else begin
        rx_run <= rx_run - 1;
      end
    end
  end

  // stimulus
  initial begin
    lookup_t pred;
    logic [PAGE_NUM_W-1:0] pg;
    int burst_left;
    int hot_base;
    int n;
    int k;

    burst_left = 0;
    hot_base = 0;
    shadow_hits = '0;
    for (n = 0; n < FRAMES; n++) begin
      shadow_page[n] = '0;
      shadow_valid[n] = 1'b0;
      shadow_age[n] = '0;
    end
    for (n = 0; n < POOL_N; n++) page_pool[n] = PAGE_NUM_W'($urandom);

    // fill into empty frames, then hits, with extreme page numbers
    add_row(16'h0000, 1'b1, 1'b0, 0, 0);
    add_row(16'hFFFF, 1'b1, 1'b0, 1, 0);
    add_row(16'h0000, 1'b1, 1'b1, 0, 1);
    add_row(16'hFFFF, 1'b1, 1'b1, 1, 2);
    add_row(16'h5555, 1'b1, 1'b0, 2, 2);
    add_row(16'hAAAA, 1'b1, 1'b0, 3, 2);
    add_row(16'h8000, 1'b0, 1'b0, 0, 0);
    add_row(16'h0001, 1'b0, 1'b0, 0, 0);
    add_row(16'h00FF, 1'b0, 1'b0, 0, 0);
    add_row(16'hFF00, 1'b0, 1'b0, 0, 0);
    add_row(16'h5555, 1'b0, 1'b0, 0, 0);
    add_row(16'h8000, 1'b0, 1'b0, 0, 0);
    add_row(16'h0000, 1'b0, 1'b0, 0, 0);
    add_row(16'h1234, 1'b0, 1'b0, 0, 0);
    add_row(16'hFFFF, 1'b0, 1'b0, 0, 0);
    add_row(16'h0001, 1'b0, 1'b0, 0, 0);
    add_row(16'hAAAA, 1'b0, 1'b0, 0, 0);
    add_row(16'h7FFF, 1'b0, 1'b0, 0, 0);
    add_row(16'h00FF, 1'b0, 1'b0, 0, 0);
    add_row(16'h7FFF, 1'b0, 1'b0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_page(directed_rows[i].page, $urandom_range(0, 2));
      pred = lookup_page(directed_rows[i].page);
      lookups_due.push_back(directed_rows[i].typed ? directed_rows[i].want : pred);
    end

    // working set with drifting hot window so the table fills and ages matter
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 99) hot_base = $urandom_range(0, POOL_N - 1);
      if (n == 700) begin
        s_tvalid <= 1'b0;
        while (lookups_due.size() != 0) @(posedge clk);
      end
      k = $urandom_range(0, 99);
      if (k < 55) pg = page_pool[(hot_base + $urandom_range(0, HOT_N - 1)) % POOL_N];
      else if (k < 90) pg = page_pool[$urandom_range(0, POOL_N - 1)];
      else pg = PAGE_NUM_W'($urandom);
      offer_page(pg, pick_gap(n, burst_left));
      pred = lookup_page(pg);
      lookups_due.push_back(pred);
    end
    s_tvalid <= 1'b0;
    drain_all = 1'b1;

    while (lookups_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
design/apr_pkg.sv
design/apr_ctrl.sv
design/apr_dp.sv
design/aging_page_replacement.sv
design/apr_checker.sv
verif/aging_page_replacement_tb.sv
